// File: rtl/des_pkg.sv
// DES package: shared block type, permutation and S-box tables, and the
// bit-select functions used by the round cells and the top level.
// No dependencies.
package des_pkg;

  // Halves of the data block travelling down the round chain.
  typedef struct packed {
    logic [31:0] l;
    logic [31:0] r;
    logic        fin;
  } des_lr_t;

  localparam int unsigned NumRounds = 16;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
    6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
    6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
    6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
    6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Left rotation of the C and D halves applied before each round.
  localparam logic [1:0] ROT_TAB [NumRounds] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [3:0] SBOX_TAB [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
  };

  // In every table, entry 1 names the most significant bit of the source.
  function automatic logic [63:0] ip_perm(input logic [63:0] v);
    logic [63:0] res;
    res = '0;
    for (int k = 0; k < 64; k++) res[63-k] = v[6'(7'd64 - IP_TAB[k])];
    return res;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] v);
    logic [63:0] res;
    res = '0;
    for (int k = 0; k < 64; k++) res[63-k] = v[6'(7'd64 - FP_TAB[k])];
    return res;
  endfunction

  function automatic logic [55:0] pc1_perm(input logic [63:0] v);
    logic [55:0] res;
    res = '0;
    for (int k = 0; k < 56; k++) res[55-k] = v[6'(7'd64 - PC1_TAB[k])];
    return res;
  endfunction

  function automatic logic [47:0] pc2_perm(input logic [55:0] v);
    logic [47:0] res;
    res = '0;
    for (int k = 0; k < 48; k++) res[47-k] = v[6'(7'd56 - {1'b0, PC2_TAB[k]})];
    return res;
  endfunction

  function automatic logic [47:0] e_expand(input logic [31:0] v);
    logic [47:0] res;
    res = '0;
    for (int k = 0; k < 48; k++) res[47-k] = v[5'(6'd32 - E_TAB[k])];
    return res;
  endfunction

  function automatic logic [31:0] p_perm(input logic [31:0] v);
    logic [31:0] res;
    res = '0;
    for (int k = 0; k < 32; k++) res[31-k] = v[5'(6'd32 - P_TAB[k])];
    return res;
  endfunction

  // Eight S-boxes; the outer bits of each six-bit group pick the row.
  function automatic logic [31:0] sbox_sub(input logic [47:0] x);
    logic [31:0] res;
    logic [5:0]  six;
    res = '0;
    for (int s = 0; s < 8; s++) begin
      six = x[47-6*s -: 6];
      res[31-4*s -: 4] = SBOX_TAB[s][{six[5], six[0], six[4:1]}];
    end
    return res;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [1:0] amt);
    logic [55:0] dbl;
    dbl = {v, v} << amt;
    return dbl[55:28];
  endfunction

endpackage

// File: rtl/des_ifs.sv
// Valid/ready channel interfaces of the DES block: key write, plaintext
// beats in and ciphertext beats out. No dependencies.
interface des_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_key;
  modport source (output valid, output cipher_key, input ready);
  modport sink (input valid, input cipher_key, output ready);
endinterface

interface des_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_block;
  logic        final_block;
  modport source (output valid, output plain_block, output final_block, input ready);
  modport sink (input valid, input plain_block, input final_block, output ready);
endinterface

interface des_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_block;
  logic        final_out;
  modport source (output valid, output cipher_block, output final_out, input ready);
  modport sink (input valid, input cipher_block, input final_out, output ready);
endinterface

// File: rtl/des_block_encrypt.sv
// DES ECB encryptor top level: key register, key schedule wiring and a
// chain of sixteen round cells. Depends on des_pkg, des_ifs and des_round.
//
//   channel  direction  payload                         handshake
//   cfg_ch   in         cipher_key[63:0]                valid/ready, ready tied high
//   in_ch    in         plain_block[63:0], final_block  valid/ready
//   out_ch   out        cipher_block[63:0], final_out   valid/ready
//
// One beat is accepted per clock cycle when the chain is free; a block
// passes through the round cells' registers in order and leaves from the last.
// Reset clears every cell's valid flag and sets the key to all zeros.
// When out_ch stalls, cells fill up from the end backwards, so the input
// keeps taking beats until the last empty cell is used up.
// The key must only be written while no block is in flight.
module des_block_encrypt (
  input  logic       clk,
  input  logic       rst_n,
  des_cfg_if.sink    cfg_ch,
  des_in_if.sink     in_ch,
  des_out_if.source  out_ch
);

  localparam int unsigned NumRounds = des_pkg::NumRounds;

  logic [63:0]      cipher_key_r;
  logic [63:0]      cipher_key_nxt;
  logic [55:0]      cd_init;
  logic [27:0]      c_sched [NumRounds+1];
  logic [27:0]      d_sched [NumRounds+1];
  logic [47:0]      subkey  [NumRounds];
  logic             stg_valid [NumRounds+1];
  logic             stg_ready [NumRounds+1];
  des_pkg::des_lr_t stg_data  [NumRounds+1];
  logic [63:0]      ip_out;

  // The key register always takes a write; the user must write only while idle (not enforced).
  assign cfg_ch.ready   = 1'b1;
  assign cipher_key_nxt = cfg_ch.valid ? cfg_ch.cipher_key : cipher_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r <= '0;
    end else begin
      cipher_key_r <= cipher_key_nxt;
    end
  end

  // Key schedule: PC-1 splits the key into C and D, each round rotates both
  // halves left and PC-2 picks the 48-bit subkey. The user must keep the key
  // steady while blocks are in flight (not enforced); this is plain wiring off the key register.
  assign cd_init    = des_pkg::pc1_perm(cipher_key_r);
  assign c_sched[0] = cd_init[55:28];
  assign d_sched[0] = cd_init[27:0];

  for (genvar g = 0; g < NumRounds; g++) begin : g_sched
    assign c_sched[g+1] = des_pkg::rotl28(c_sched[g], des_pkg::ROT_TAB[g]);
    assign d_sched[g+1] = des_pkg::rotl28(d_sched[g], des_pkg::ROT_TAB[g]);
    assign subkey[g]    = des_pkg::pc2_perm({c_sched[g+1], d_sched[g+1]});
  end

  // Initial permutation feeds the first cell directly.
  assign ip_out           = des_pkg::ip_perm(in_ch.plain_block);
  assign stg_valid[0]     = in_ch.valid;
  assign in_ch.ready      = stg_ready[0];
  assign stg_data[0].l    = ip_out[63:32];
  assign stg_data[0].r    = ip_out[31:0];
  assign stg_data[0].fin  = in_ch.final_block;

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    des_round u_round (
      .clk        (clk),
      .rst_n      (rst_n),
      .subkey     (subkey[g]),
      .up_valid   (stg_valid[g]),
      .up_ready   (stg_ready[g]),
      .up_data    (stg_data[g]),
      .down_valid (stg_valid[g+1]),
      .down_ready (stg_ready[g+1]),
      .down_data  (stg_data[g+1])
    );
  end

  // The last cell's register is the output register; the halves are swapped
  // before the inverse initial permutation.
  assign out_ch.valid          = stg_valid[NumRounds];
  assign stg_ready[NumRounds]  = out_ch.ready;
  assign out_ch.cipher_block   = des_pkg::fp_perm({stg_data[NumRounds].r,
                                                   stg_data[NumRounds].l});
  assign out_ch.final_out      = stg_data[NumRounds].fin;

endmodule

// File: rtl/des_round.sv
// One Feistel round cell of the DES chain, with its own pipeline register
// and valid/ready handshake. Depends on des_pkg.
module des_round (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [47:0]      subkey,
  input  logic             up_valid,
  output logic             up_ready,
  input  des_pkg::des_lr_t up_data,
  output logic             down_valid,
  input  logic             down_ready,
  output des_pkg::des_lr_t down_data
);

  logic             valid_r;
  logic             valid_nxt;
  des_pkg::des_lr_t data_r;
  des_pkg::des_lr_t data_nxt;
  logic [31:0]      f_out;

  // The cell takes a beat when it is empty or its own beat leaves now.
  assign up_ready = !valid_r || down_ready;

  assign f_out = des_pkg::p_perm(des_pkg::sbox_sub(des_pkg::e_expand(up_data.r) ^ subkey));

  always_comb begin
    valid_nxt    = up_ready ? up_valid : valid_r;
    data_nxt     = data_r;
    if (up_valid && up_ready) begin
      data_nxt.l   = up_data.r;
      data_nxt.r   = up_data.l ^ f_out;
      data_nxt.fin = up_data.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign down_valid = valid_r;
  assign down_data  = data_r;

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    up_valid && up_ready |=> valid_r)
    else $error("des_round: accepted beat did not land in the cell");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> up_ready)
    else $error("des_round: empty cell refused a beat");

  a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !down_ready |-> !up_ready)
    else $error("des_round: full stalled cell offered to take a beat");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    !up_valid && up_ready |=> !valid_r)
    else $error("des_round: cell kept a beat after it left");

endmodule
